// ===== hdl/sounding_ref_subcarrier_mapper_macros.svh =====
// Assertion macros shared by the sounding reference mapper RTL.
// Uses the clk and rst_n names of the module that expands them.
`ifndef SOUNDING_REF_SUBCARRIER_MAPPER_MACROS_SVH
`define SOUNDING_REF_SUBCARRIER_MAPPER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define SRSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SRSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRSM_ASSERT_IMP(lbl, ante, cons, msg)
`define SRSM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/srsm_pkg.sv =====
// Package of the sounding reference subcarrier mapper: widths, types,
// bandwidth and subframe tables, small lookup functions. No dependencies.
package srsm_pkg;

  localparam int SYMBOLS_PER_SUBFRAME = 14;
  localparam int MAX_TRANSFORM        = 2048;

  localparam int MSC_PER_RB   = 6;
  localparam int RB_INVALID   = 111;
  localparam int Q_SHIFT      = 15;
  localparam int SHORT_PERIOD = 5;
  localparam int LONG_PERIOD  = 10;

  localparam int SAMPLE_W  = 16;
  localparam int TS_W      = 12;
  localparam int CP_W      = TS_W;
  localparam int CNT_W     = 10;
  localparam int IDX_W     = 19;
  localparam int ROW_W     = 8;
  localparam int K0_W      = 21;
  localparam int ACC_W     = 20;
  localparam int MUL_W     = 16;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = 20;
  localparam int DIVR_W    = TS_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic        [SAMPLE_W-1:0]  usample_t;
  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic        [CP_W-1:0]      cp_t;
  typedef logic        [CP_W:0]        cp_ext_t;
  typedef logic        [TS_W:0]        ts_ext_t;
  typedef logic        [CNT_W-1:0]     cnt_t;
  typedef logic        [IDX_W-1:0]     idx_t;
  typedef logic        [ROW_W-1:0]     row_t;
  typedef logic signed [K0_W-1:0]      k0_t;
  typedef logic        [ACC_W-1:0]     acc_t;
  typedef logic signed [MUL_W-1:0]     mul_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic        [DIV_W-1:0]     div_t;
  typedef logic        [DIVR_W-1:0]    divr_t;
  typedef logic        [DIV_CNT_W-1:0] div_cnt_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPLINK_RB      = 3'd0,
    REG_BW_CONFIG      = 3'd1,
    REG_BW_INDEX       = 3'd2,
    REG_SF_CONFIG      = 3'd3,
    REG_FREQ_POS       = 3'd4,
    REG_COMB           = 3'd5,
    REG_FIRST_CARRIER  = 3'd6,
    REG_TRANSFORM_SIZE = 3'd7
  } cfg_reg_e;

  // Per-item status codes, also the run status of a sequence
  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_INVALID = 2'd2,
    ST_IDLE    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DIV_Q,
    S_DIV_NB,
    S_MUL_NB,
    S_K0,
    S_CHECK,
    S_DIV_CP,
    S_SCALE_RE,
    S_SCALE_IM,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [6:0]  uplink_resource_blocks;
    logic [2:0]  bandwidth_config;
    logic [1:0]  bandwidth_index;
    logic [3:0]  subframe_config;
    logic [7:0]  frequency_position;
    logic        comb_offset;
    logic [10:0] first_carrier;
    logic [11:0] transform_size;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    uplink_resource_blocks: 7'd25,
    bandwidth_config:       3'd0,
    bandwidth_index:        2'd0,
    subframe_config:        4'd0,
    frequency_position:     8'd0,
    comb_offset:            1'b0,
    first_carrier:          11'd0,
    transform_size:         12'd512
  };

  typedef struct packed {
    logic    first;
    logic [3:0] subframe;
    sample_t amplitude;
    sample_t ref_real;
    sample_t ref_imag;
  } in_item_t;

  typedef struct packed {
    status_e status;
    idx_t    element_index;
    sample_t out_real;
    sample_t out_imag;
    logic    last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sounding bandwidths [resource block group][bandwidth config][bandwidth index]
  localparam logic [6:0] BW_TABLE [4][8][4] = '{
    '{'{7'd36, 7'd12, 7'd4, 7'd4}, '{7'd32, 7'd16, 7'd8, 7'd4},
      '{7'd24, 7'd4, 7'd4, 7'd4},  '{7'd20, 7'd4, 7'd4, 7'd4},
      '{7'd16, 7'd4, 7'd4, 7'd4},  '{7'd12, 7'd4, 7'd4, 7'd4},
      '{7'd8, 7'd4, 7'd4, 7'd4},   '{7'd4, 7'd4, 7'd4, 7'd4}},
    '{'{7'd48, 7'd24, 7'd12, 7'd4}, '{7'd48, 7'd16, 7'd8, 7'd4},
      '{7'd40, 7'd20, 7'd4, 7'd4},  '{7'd36, 7'd12, 7'd4, 7'd4},
      '{7'd32, 7'd16, 7'd8, 7'd4},  '{7'd24, 7'd4, 7'd4, 7'd4},
      '{7'd20, 7'd4, 7'd4, 7'd4},   '{7'd16, 7'd4, 7'd4, 7'd4}},
    '{'{7'd72, 7'd24, 7'd12, 7'd4}, '{7'd64, 7'd32, 7'd16, 7'd4},
      '{7'd60, 7'd20, 7'd4, 7'd4},  '{7'd48, 7'd24, 7'd12, 7'd4},
      '{7'd48, 7'd16, 7'd8, 7'd4},  '{7'd40, 7'd20, 7'd4, 7'd4},
      '{7'd36, 7'd12, 7'd4, 7'd4},  '{7'd32, 7'd16, 7'd8, 7'd4}},
    '{'{7'd96, 7'd48, 7'd24, 7'd4}, '{7'd96, 7'd32, 7'd16, 7'd4},
      '{7'd80, 7'd40, 7'd20, 7'd4}, '{7'd72, 7'd24, 7'd12, 7'd4},
      '{7'd64, 7'd32, 7'd16, 7'd4}, '{7'd60, 7'd20, 7'd4, 7'd4},
      '{7'd48, 7'd24, 7'd12, 7'd4}, '{7'd48, 7'd16, 7'd8, 7'd4}}
  };

  // Sounding subframe masks per subframe configuration
  localparam logic [9:0] OFFSET_MASK [16] = '{
    10'd2, 10'd6, 10'd10, 10'd18, 10'd14, 10'd22, 10'd26, 10'd30,
    10'd70, 10'd74, 10'd194, 10'd326, 10'd586, 10'd210, 10'd0, 10'd0
  };

  // Table group from the uplink bandwidth
  function automatic logic [1:0] bw_group(input logic [6:0] nrb);
    logic [1:0] grp;
    if (nrb < 7'd41) begin
      grp = 2'd0;
    end else if (nrb < 7'd61) begin
      grp = 2'd1;
    end else if (nrb < 7'd81) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
    return grp;
  endfunction

  // Subframe number modulo the sounding period (5 or 10)
  function automatic logic [3:0] sf_phase(input logic [3:0] sf, input logic long_period);
    logic [3:0] r;
    r = sf;
    if (r >= 4'(LONG_PERIOD)) begin
      r = r - 4'(LONG_PERIOD);
    end
    if (!long_period && r >= 4'(SHORT_PERIOD)) begin
      r = r - 4'(SHORT_PERIOD);
    end
    return r;
  endfunction

endpackage

// ===== hdl/srsm_if.sv =====
// Valid/ready channel interfaces of the sounding reference mapper:
// sample input, result output and configuration write. Uses srsm_pkg.
interface srsm_in_if;
  logic                valid;
  logic                ready;
  srsm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srsm_out_if;
  logic                valid;
  logic                ready;
  srsm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srsm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [srsm_pkg::CFG_IDX_W-1:0]    index;
  logic [srsm_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/srsm_cfg_regs.sv =====
// Configuration register file of the sounding reference mapper.
// Depends on srsm_pkg and the srsm_cfg_if channel.
module srsm_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  srsm_cfg_if.sink       cfg_ch,
  output srsm_pkg::cfg_t cfg
);

  srsm_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg           = cfg_r;

  // Write one register per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= srsm_pkg::CFG_RESET;
    end else if (cfg_ch.valid) begin
      case (srsm_pkg::cfg_reg_e'(cfg_ch.index))
        srsm_pkg::REG_UPLINK_RB:      cfg_r.uplink_resource_blocks <= cfg_ch.data[6:0];
        srsm_pkg::REG_BW_CONFIG:      cfg_r.bandwidth_config       <= cfg_ch.data[2:0];
        srsm_pkg::REG_BW_INDEX:       cfg_r.bandwidth_index        <= cfg_ch.data[1:0];
        srsm_pkg::REG_SF_CONFIG:      cfg_r.subframe_config        <= cfg_ch.data[3:0];
        srsm_pkg::REG_FREQ_POS:       cfg_r.frequency_position     <= cfg_ch.data[7:0];
        srsm_pkg::REG_COMB:           cfg_r.comb_offset            <= cfg_ch.data[0];
        srsm_pkg::REG_FIRST_CARRIER:  cfg_r.first_carrier          <= cfg_ch.data[10:0];
        srsm_pkg::REG_TRANSFORM_SIZE: cfg_r.transform_size         <= cfg_ch.data[11:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

endmodule

// ===== hdl/srsm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on srsm_pkg and the assertion macro header.
`include "sounding_ref_subcarrier_mapper_macros.svh"

module srsm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  srsm_pkg::div_t      dividend,
  input  srsm_pkg::divr_t     divisor,
  output srsm_pkg::div_t      quotient,
  output srsm_pkg::divr_t     remainder,
  output srsm_pkg::div_stat_t stat
);

  srsm_pkg::div_t     quo_r;
  srsm_pkg::divr_t    rem_r;
  srsm_pkg::divr_t    divisor_r;
  srsm_pkg::div_cnt_t cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [srsm_pkg::DIVR_W:0] shifted;
  logic [srsm_pkg::DIVR_W:0] diff;
  logic                      ge;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem_r, quo_r[srsm_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, divisor_r};
  assign diff    = shifted - {1'b0, divisor_r};

  // Control: count the quotient bits, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= srsm_pkg::div_cnt_t'(srsm_pkg::DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - srsm_pkg::div_cnt_t'(1);
        end
      end
    end
  end

  // Datapath: load operands, then one step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[srsm_pkg::DIV_W-2:0], ge};
      rem_r <= ge ? diff[srsm_pkg::DIVR_W-1:0] : shifted[srsm_pkg::DIVR_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

  `SRSM_ASSERT_NXT(a_div_start_runs, start, busy_r && !done_r, "divider did not start")
  `SRSM_ASSERT_IMP(a_div_done_after_busy, done_r, !busy_r && $past(busy_r), "stray done")
  `SRSM_ASSERT_NXT(a_div_last_step, busy_r && cnt_r == '0 && !start, done_r, "done missing")

endmodule

// ===== hdl/srsm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on srsm_pkg.
module srsm_mul (
  input  logic            clk,
  input  logic            en,
  input  srsm_pkg::mul_t  a,
  input  srsm_pkg::mul_t  b,
  output srsm_pkg::prod_t prod
);

  srsm_pkg::prod_t prod_r;

  // Hold the product while not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

// ===== hdl/sounding_ref_subcarrier_mapper.sv =====
// Sounding reference subcarrier mapper, top level.
// Channels: in_ch takes one reference sample per item (first, subframe, Q15 amplitude,
// real and imaginary part); out_ch gives one result item per input item (status, grid
// element index, scaled sample, last flag); cfg_ch writes the eight setup registers,
// which are read while a first item is being set up; transform_size is also read for
// the carrier wrap of every placed item.
// Flow: an ordinary item is taken in S_IDLE, scaled in S_SCALE_RE and S_SCALE_IM and
// registered as a result in S_RESULT; the next item is taken only after that. The two
// scaling products go one after the other through a single shared multiplier.
// A first item also sets up the placement before its scaling: three passes of the
// shared 20-step divider (4*position/msrsb, then mod msrsb, then the start carrier mod
// transform_size). A first that does not sound or has a negative start offset k0
// skips the last pass; invalid registers skip the whole setup.
// Reset: registers go to their reset values, no sequence is active, so items report
// status 3 until a first item arrives.
// Stall: the result register frees the input side; a new item is taken while a result
// waits. If a second result is ready before the first is taken, the block holds it
// and stays not ready until out_ch moves.
// Depends on srsm_pkg, srsm_if, srsm_cfg_regs, srsm_div, srsm_mul and the macro header.
`include "sounding_ref_subcarrier_mapper_macros.svh"

module sounding_ref_subcarrier_mapper (
  input  logic       clk,
  input  logic       rst_n,
  srsm_in_if.sink    in_ch,
  srsm_out_if.source out_ch,
  srsm_cfg_if.sink   cfg_ch
);

  srsm_pkg::cfg_t      cfg;

  srsm_pkg::state_e    state_r, state_nxt;
  srsm_pkg::in_item_t  item_r, item_nxt;
  srsm_pkg::status_e   run_status_r, run_status_nxt;
  srsm_pkg::cp_t       carrier_r, carrier_nxt;
  srsm_pkg::cnt_t      count_r, count_nxt;
  srsm_pkg::cnt_t      length_r, length_nxt;
  srsm_pkg::idx_t      symbase_r, symbase_nxt;
  srsm_pkg::k0_t       base_r, base_nxt;
  srsm_pkg::k0_t       k0_r, k0_nxt;
  srsm_pkg::acc_t      acc_r, acc_nxt;
  srsm_pkg::sample_t   re_r, re_nxt;
  srsm_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                div_start;
  srsm_pkg::div_t      div_dividend;
  srsm_pkg::divr_t     div_divisor;
  srsm_pkg::div_t      div_quo;
  srsm_pkg::divr_t     div_rem;
  srsm_pkg::div_stat_t div_stat;

  logic                mul_en;
  srsm_pkg::mul_t      mul_a;
  srsm_pkg::mul_t      mul_b;
  srsm_pkg::prod_t     mul_prod;

  logic [1:0]          grp;
  logic [6:0]          msrs0;
  logic [6:0]          msrsb;
  srsm_pkg::cnt_t      msc;
  logic                params_bad;
  srsm_pkg::k0_t       half_diff;
  srsm_pkg::k0_t       base_calc;
  srsm_pkg::acc_t      nb_msc;
  srsm_pkg::acc_t      acc_calc;
  srsm_pkg::row_t      row;
  logic [3:0]          phase;
  logic                sounds;
  srsm_pkg::cp_ext_t   cp_step;
  srsm_pkg::cnt_t      count_inc;
  srsm_pkg::out_item_t res;
  logic                res_advance;
  logic                out_load;

  srsm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  srsm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  srsm_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  // Bandwidth table lookup and parameter check
  assign grp        = srsm_pkg::bw_group(cfg.uplink_resource_blocks);
  assign msrs0      = srsm_pkg::BW_TABLE[grp][cfg.bandwidth_config][0];
  assign msrsb      = srsm_pkg::BW_TABLE[grp][cfg.bandwidth_config][cfg.bandwidth_index];
  assign msc        = srsm_pkg::cnt_t'(msrsb) * srsm_pkg::cnt_t'(srsm_pkg::MSC_PER_RB);
  assign params_bad = (cfg.uplink_resource_blocks >= 7'(srsm_pkg::RB_INVALID))
                   || (cfg.transform_size == '0)
                   || (srsm_pkg::ts_ext_t'(cfg.transform_size)
                       > srsm_pkg::ts_ext_t'(srsm_pkg::MAX_TRANSFORM));

  // Start offset without the hopping term: (nrb/2 - msrs0/2) * 12 + comb
  assign half_diff = srsm_pkg::k0_t'(cfg.uplink_resource_blocks >> 1)
                   - srsm_pkg::k0_t'(msrs0 >> 1);
  assign base_calc = (half_diff <<< 3) + (half_diff <<< 2)
                   + srsm_pkg::k0_t'(cfg.comb_offset);

  // Hopping term: nb*msc times 2*(bandwidth_index+1)
  assign nb_msc = srsm_pkg::acc_t'(mul_prod[srsm_pkg::MUL_W-1:0]);
  always_comb begin
    case (cfg.bandwidth_index)
      2'd0:    acc_calc = nb_msc << 1;
      2'd1:    acc_calc = nb_msc << 2;
      2'd2:    acc_calc = (nb_msc << 1) + (nb_msc << 2);
      default: acc_calc = nb_msc << 3;
    endcase
  end

  // Last symbol of the subframe and the sounding subframe test
  assign row    = srsm_pkg::row_t'(item_r.subframe)
                * srsm_pkg::row_t'(srsm_pkg::SYMBOLS_PER_SUBFRAME)
                + srsm_pkg::row_t'(srsm_pkg::SYMBOLS_PER_SUBFRAME - 1);
  assign phase  = srsm_pkg::sf_phase(item_r.subframe, cfg.subframe_config[3]);
  assign sounds = srsm_pkg::OFFSET_MASK[cfg.subframe_config][phase];

  // Result of the current item from the run state
  assign cp_step   = srsm_pkg::cp_ext_t'(carrier_r) + srsm_pkg::cp_ext_t'(2);
  assign count_inc = count_r + srsm_pkg::cnt_t'(1);
  always_comb begin
    res         = '0;
    res.status  = srsm_pkg::ST_IDLE;
    res_advance = 1'b0;
    if (run_status_r == srsm_pkg::ST_INVALID) begin
      res.status = srsm_pkg::ST_INVALID;
    end else if (run_status_r == srsm_pkg::ST_IDLE || count_r >= length_r) begin
      res.status = srsm_pkg::ST_IDLE;
    end else begin
      res.status  = run_status_r;
      res_advance = 1'b1;
      res.last    = (count_inc == length_r);
      if (run_status_r == srsm_pkg::ST_PLACED) begin
        res.element_index = symbase_r + srsm_pkg::idx_t'(carrier_r);
        res.out_real      = re_r;
        res.out_imag      = mul_prod[srsm_pkg::Q_SHIFT +: srsm_pkg::SAMPLE_W];
      end
    end
  end

  assign out_load = (state_r == srsm_pkg::S_RESULT) && (!out_valid_r || out_ch.ready);

  // Sequencer: next state, datapath loads, shared unit operands
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    run_status_nxt = run_status_r;
    carrier_nxt    = carrier_r;
    count_nxt      = count_r;
    length_nxt     = length_r;
    symbase_nxt    = symbase_r;
    base_nxt       = base_r;
    k0_nxt         = k0_r;
    acc_nxt        = acc_r;
    re_nxt         = re_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    div_start      = 1'b0;
    div_dividend   = div_quo;
    div_divisor    = srsm_pkg::divr_t'(msrsb);
    mul_en         = 1'b0;
    mul_a          = item_r.amplitude;
    mul_b          = item_r.ref_real;

    case (state_r)
      srsm_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          state_nxt = in_ch.data.first ? srsm_pkg::S_START : srsm_pkg::S_SCALE_RE;
        end
      end
      srsm_pkg::S_START: begin
        count_nxt   = '0;
        length_nxt  = '0;
        carrier_nxt = '0;
        symbase_nxt = '0;
        if (params_bad) begin
          run_status_nxt = srsm_pkg::ST_INVALID;
          state_nxt      = srsm_pkg::S_SCALE_RE;
        end else begin
          base_nxt     = base_calc;
          div_start    = 1'b1;
          div_dividend = srsm_pkg::div_t'({cfg.frequency_position, 2'b00});
          state_nxt    = srsm_pkg::S_DIV_Q;
        end
      end
      srsm_pkg::S_DIV_Q: begin
        // quotient of 4*position/msrsb, reduce it mod msrsb next
        if (div_stat.done) begin
          div_start = 1'b1;
          state_nxt = srsm_pkg::S_DIV_NB;
        end
      end
      srsm_pkg::S_DIV_NB: begin
        if (div_stat.done) begin
          mul_en    = 1'b1;
          mul_a     = srsm_pkg::mul_t'(div_rem);
          mul_b     = srsm_pkg::mul_t'(msc);
          state_nxt = srsm_pkg::S_MUL_NB;
        end
      end
      srsm_pkg::S_MUL_NB: begin
        acc_nxt   = acc_calc;
        state_nxt = srsm_pkg::S_K0;
      end
      srsm_pkg::S_K0: begin
        k0_nxt    = base_r + srsm_pkg::k0_t'(acc_r);
        mul_en    = 1'b1;
        mul_a     = srsm_pkg::mul_t'(row);
        mul_b     = srsm_pkg::mul_t'(cfg.transform_size);
        state_nxt = srsm_pkg::S_CHECK;
      end
      srsm_pkg::S_CHECK: begin
        if (k0_r < srsm_pkg::k0_t'(0)) begin
          run_status_nxt = srsm_pkg::ST_INVALID;
          state_nxt      = srsm_pkg::S_SCALE_RE;
        end else begin
          length_nxt = msc;
          if (!sounds) begin
            run_status_nxt = srsm_pkg::ST_SKIPPED;
            state_nxt      = srsm_pkg::S_SCALE_RE;
          end else begin
            symbase_nxt  = mul_prod[srsm_pkg::IDX_W-1:0];
            div_start    = 1'b1;
            div_dividend = srsm_pkg::div_t'(cfg.first_carrier) + srsm_pkg::div_t'(k0_r);
            div_divisor  = cfg.transform_size;
            state_nxt    = srsm_pkg::S_DIV_CP;
          end
        end
      end
      srsm_pkg::S_DIV_CP: begin
        if (div_stat.done) begin
          carrier_nxt    = div_rem;
          run_status_nxt = srsm_pkg::ST_PLACED;
          state_nxt      = srsm_pkg::S_SCALE_RE;
        end
      end
      srsm_pkg::S_SCALE_RE: begin
        mul_en    = 1'b1;
        state_nxt = srsm_pkg::S_SCALE_IM;
      end
      srsm_pkg::S_SCALE_IM: begin
        mul_en    = 1'b1;
        mul_b     = item_r.ref_imag;
        re_nxt    = mul_prod[srsm_pkg::Q_SHIFT +: srsm_pkg::SAMPLE_W];
        state_nxt = srsm_pkg::S_RESULT;
      end
      srsm_pkg::S_RESULT: begin
        // hold until the result register is free
        if (out_load) begin
          out_data_nxt  = res;
          out_valid_nxt = 1'b1;
          state_nxt     = srsm_pkg::S_IDLE;
          if (res_advance) begin
            count_nxt = count_inc;
            if (res.last) begin
              run_status_nxt = srsm_pkg::ST_IDLE;
            end
            if (run_status_r == srsm_pkg::ST_PLACED) begin
              if (cp_step >= srsm_pkg::cp_ext_t'(cfg.transform_size)) begin
                carrier_nxt = srsm_pkg::cp_t'(1);
              end else begin
                carrier_nxt = cp_step[srsm_pkg::CP_W-1:0];
              end
            end
          end
        end
      end
      default: begin
        state_nxt = srsm_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srsm_pkg::S_IDLE;
      run_status_r <= srsm_pkg::ST_IDLE;
      carrier_r    <= '0;
      count_r      <= '0;
      length_r     <= '0;
      symbase_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_status_r <= run_status_nxt;
      carrier_r    <= carrier_nxt;
      count_r      <= count_nxt;
      length_r     <= length_nxt;
      symbase_r    <= symbase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    base_r     <= base_nxt;
    k0_r       <= k0_nxt;
    acc_r      <= acc_nxt;
    re_r       <= re_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready  = (state_r == srsm_pkg::S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `SRSM_ASSERT_IMP(a_unplaced_fields_zero, out_valid_r && out_data_r.status != srsm_pkg::ST_PLACED, out_data_r.element_index == '0 && out_data_r.out_real == '0 && out_data_r.out_imag == '0, "unplaced item carries data")
  `SRSM_ASSERT_IMP(a_last_in_sequence, out_valid_r && out_data_r.last, out_data_r.status == srsm_pkg::ST_PLACED || out_data_r.status == srsm_pkg::ST_SKIPPED, "last outside a sequence")
  `SRSM_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the sounding reference subcarrier mapper: directed and random
// sample streams, setup changes between soundings, field-by-field checks of every result.
// Needs srsm_pkg, the srsm channel interfaces and the mapper top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SAMPLES = 850;
  localparam int SC_PER_RB      = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 80;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int MAX_REPORTS    = 40;

  logic clk = 1'b0;
  logic rst_n;

  srsm_in_if  in_ch ();
  srsm_out_if out_ch ();
  srsm_cfg_if cfg_ch ();

  sounding_ref_subcarrier_mapper uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Setup registers as written, plus the placement of the running sounding
  srsm_pkg::cfg_t    reg_shadow = srsm_pkg::CFG_RESET;
  srsm_pkg::status_e run_state = srsm_pkg::ST_IDLE;
  int        carrier = 0;
  int        sample_count = 0;
  int        seq_length = 0;
  int        symbol_base = 0;

  srsm_pkg::in_item_t  pending_samples[$];
  srsm_pkg::out_item_t expected_elements[$];

  int send_idle_pct = 6;
  int recv_idle_pct = 86;
  int samples_issued = 0;
  int samples_accepted = 0;
  int queued_total = 0;
  int mismatches = 0;
  int cycles = 0;
  int setups = 0;
  int lasts_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  // Sounding bandwidth in one table column for the resource block group of a setup
  function automatic int bw_entry(srsm_pkg::cfg_t c, int col);
    int nrb;
    int grp;
    nrb = c.uplink_resource_blocks;
    grp = (nrb < 41) ? 0 : (nrb < 61) ? 1 : (nrb < 81) ? 2 : 3;
    return srsm_pkg::BW_TABLE[grp][c.bandwidth_config][col];
  endfunction

  function automatic bit subframe_sounds(srsm_pkg::cfg_t c, int sf);
    int period;
    period = (c.subframe_config <= 7) ? srsm_pkg::SHORT_PERIOD : srsm_pkg::LONG_PERIOD;
    return srsm_pkg::OFFSET_MASK[c.subframe_config][sf % period];
  endfunction

  // Q15 scaling: floor shift, then keep the low 16 bits
  function automatic srsm_pkg::sample_t q15_scale(srsm_pkg::sample_t amp,
                                                  srsm_pkg::sample_t x);
    int prod;
    prod = int'(amp) * int'(x);
    return srsm_pkg::sample_t'(prod >>> srsm_pkg::Q_SHIFT);
  endfunction

  // Work out the result of one accepted sample and advance the sounding state
  function automatic void map_sample(srsm_pkg::in_item_t it);
    srsm_pkg::out_item_t want;
    int nrb, ts, msrs0, msrsb, msc, nb, k0, fp, bi, sf;
    if (it.first) begin
      nrb = reg_shadow.uplink_resource_blocks;
      ts = reg_shadow.transform_size;
      fp = reg_shadow.frequency_position;
      bi = reg_shadow.bandwidth_index;
      sf = it.subframe;
      sample_count = 0;
      seq_length = 0;
      carrier = 0;
      symbol_base = 0;
      if (nrb >= srsm_pkg::RB_INVALID || ts == 0 || ts > srsm_pkg::MAX_TRANSFORM) begin
        run_state = srsm_pkg::ST_INVALID;
      end else begin
        msrs0 = bw_entry(reg_shadow, 0);
        msrsb = bw_entry(reg_shadow, bi);
        msc = msrsb * srsm_pkg::MSC_PER_RB;
        nb = ((4 * fp) / msrsb) % msrsb;
        k0 = ((nrb >> 1) - (msrs0 >> 1)) * SC_PER_RB + int'(reg_shadow.comb_offset)
             + (bi + 1) * 2 * nb * msc;
        if (k0 < 0) begin
          run_state = srsm_pkg::ST_INVALID;
        end else begin
          seq_length = msc;
          if (!subframe_sounds(reg_shadow, sf)) begin
            run_state = srsm_pkg::ST_SKIPPED;
          end else begin
            carrier = (int'(reg_shadow.first_carrier) + k0) % ts;
            symbol_base = sf * srsm_pkg::SYMBOLS_PER_SUBFRAME * ts
                        + (srsm_pkg::SYMBOLS_PER_SUBFRAME - 1) * ts;
            run_state = srsm_pkg::ST_PLACED;
          end
        end
      end
    end

    want = '0;
    want.status = srsm_pkg::ST_IDLE;
    if (run_state == srsm_pkg::ST_INVALID) begin
      want.status = srsm_pkg::ST_INVALID;
    end else if (run_state != srsm_pkg::ST_IDLE && sample_count < seq_length) begin
      want.status = run_state;
      if (run_state == srsm_pkg::ST_PLACED) begin
        want.element_index = srsm_pkg::idx_t'(symbol_base + carrier);
        want.out_real = q15_scale(it.amplitude, it.ref_real);
        want.out_imag = q15_scale(it.amplitude, it.ref_imag);
        // the wrap follows the transform size as currently written
        carrier += 2;
        if (carrier >= int'(reg_shadow.transform_size)) carrier = 1;
      end
      sample_count++;
      if (sample_count == seq_length) begin
        want.last = 1'b1;
        run_state = srsm_pkg::ST_IDLE;
      end
    end
    expected_elements.push_back(want);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want_v,
                                      logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  function automatic void queue_sample(bit first, int sf, int amp, int re, int im);
    srsm_pkg::in_item_t it;
    it.first = first;
    it.subframe = 4'(sf);
    it.amplitude = srsm_pkg::sample_t'(amp);
    it.ref_real = srsm_pkg::sample_t'(re);
    it.ref_imag = srsm_pkg::sample_t'(im);
    pending_samples.push_back(it);
    queued_total++;
  endfunction

  // Write one setup register; the shadow copy follows at the accepting edge
  task automatic write_reg(input srsm_pkg::cfg_reg_e idx, input int value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= srsm_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      srsm_pkg::REG_UPLINK_RB:      reg_shadow.uplink_resource_blocks = 7'(value);
      srsm_pkg::REG_BW_CONFIG:      reg_shadow.bandwidth_config = 3'(value);
      srsm_pkg::REG_BW_INDEX:       reg_shadow.bandwidth_index = 2'(value);
      srsm_pkg::REG_SF_CONFIG:      reg_shadow.subframe_config = 4'(value);
      srsm_pkg::REG_FREQ_POS:       reg_shadow.frequency_position = 8'(value);
      srsm_pkg::REG_COMB:           reg_shadow.comb_offset = 1'(value);
      srsm_pkg::REG_FIRST_CARRIER:  reg_shadow.first_carrier = 11'(value);
      srsm_pkg::REG_TRANSFORM_SIZE: reg_shadow.transform_size = 12'(value);
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold off the sender until every queued item has its result, then wait a little
  task automatic quiesce(input int extra);
    do @(posedge clk);
    while (pending_samples.size() != 0 || samples_issued != samples_accepted ||
           expected_elements.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Sample driver: hold an item until taken, then maybe present the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        map_sample(in_ch.data);
        samples_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.data  <= pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          samples_issued++;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken item with the oldest prediction
  always @(posedge clk) begin : result_monitor
    srsm_pkg::out_item_t want;
    srsm_pkg::out_item_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_elements.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: result item with nothing expected, expected none, got status %0d",
                     $time, got.status);
        end else begin
          want = expected_elements.pop_front();
          status_seen[int'(got.status)]++;
          if (got.last === 1'b1) lasts_seen++;
          check_field("status", want.status, got.status);
          check_field("element_index", want.element_index, got.element_index);
          check_field("out_real", want.out_real, got.out_real);
          check_field("out_imag", want.out_imag, got.out_imag);
          check_field("last", want.last, got.last);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still expected", $time, expected_elements.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int random_base, done, pick, nrb, bi, ts, msc, len, sf, tries;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // No sounding active yet, then a first under the reset setup, whose k0 is negative
    queue_sample(0, 0, 16384, 100, -100);
    queue_sample(1, 1, 16384, 100, -100);
    queue_sample(0, 5, 16384, 100, -100);
    quiesce(SETTLE_CYCLES);

    // Wide uplink, top position, comb and first carrier; period-ten subframe mask
    write_reg(srsm_pkg::REG_UPLINK_RB, 110);
    write_reg(srsm_pkg::REG_BW_CONFIG, 3);
    write_reg(srsm_pkg::REG_BW_INDEX, 2);
    write_reg(srsm_pkg::REG_SF_CONFIG, 8);
    write_reg(srsm_pkg::REG_FREQ_POS, 255);
    write_reg(srsm_pkg::REG_COMB, 1);
    write_reg(srsm_pkg::REG_FIRST_CARRIER, 2047);
    write_reg(srsm_pkg::REG_TRANSFORM_SIZE, srsm_pkg::MAX_TRANSFORM);
    // Subframe above nine, sample extremes, ignored subframe field
    queue_sample(1, 12, -32768, -32768, 32767);
    queue_sample(0, 15, 32767, 32767, -32768);
    queue_sample(0, 0, -1, 1, -1);
    queue_sample(0, 0, 0, -1, 32767);
    quiesce(SETTLE_CYCLES);

    // New register values must not touch the running sounding
    write_reg(srsm_pkg::REG_FREQ_POS, 0);
    write_reg(srsm_pkg::REG_COMB, 0);
    queue_sample(0, 3, 12345, -2222, 777);
    queue_sample(1, 0, 20000, 3000, -3000);
    queue_sample(0, 0, 20000, 3000, -3000);
    quiesce(SETTLE_CYCLES);

    // Invalid uplink sizes and transform sizes
    write_reg(srsm_pkg::REG_UPLINK_RB, 127);
    write_reg(srsm_pkg::REG_TRANSFORM_SIZE, 4095);
    queue_sample(1, 9, 1000, 1000, 1000);
    quiesce(SETTLE_CYCLES);
    write_reg(srsm_pkg::REG_UPLINK_RB, srsm_pkg::RB_INVALID);
    write_reg(srsm_pkg::REG_TRANSFORM_SIZE, srsm_pkg::MAX_TRANSFORM);
    queue_sample(1, 2, 1000, 1000, 1000);
    quiesce(SETTLE_CYCLES);
    write_reg(srsm_pkg::REG_UPLINK_RB, 0);
    write_reg(srsm_pkg::REG_BW_CONFIG, 7);
    write_reg(srsm_pkg::REG_BW_INDEX, 3);
    write_reg(srsm_pkg::REG_FREQ_POS, 3);
    write_reg(srsm_pkg::REG_SF_CONFIG, 14);
    write_reg(srsm_pkg::REG_TRANSFORM_SIZE, 0);
    queue_sample(1, 4, 1000, 1000, 1000);
    quiesce(SETTLE_CYCLES);

    // Uplink below six RBs, with a configuration that never sounds and then one that does
    write_reg(srsm_pkg::REG_TRANSFORM_SIZE, 128);
    queue_sample(1, 4, 1000, -1000, 1000);
    queue_sample(0, 4, 1000, -1000, 1000);
    quiesce(SETTLE_CYCLES);
    write_reg(srsm_pkg::REG_UPLINK_RB, 5);
    write_reg(srsm_pkg::REG_SF_CONFIG, 7);
    write_reg(srsm_pkg::REG_TRANSFORM_SIZE, 127);
    queue_sample(1, 3, -20000, 32767, -32768);
    queue_sample(0, 3, -20000, -32768, 32767);

    // Random setups, each followed by a few soundings with random samples
    random_base = queued_total;
    while (queued_total - random_base < RANDOM_SAMPLES) begin
      done = queued_total - random_base;
      if (done >= 2 * RANDOM_SAMPLES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (done >= RANDOM_SAMPLES / 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 6;
      end
      quiesce(SETTLE_CYCLES);

      pick = $urandom_range(99);
      nrb = (pick < 84) ? $urandom_range(6, 110) :
            (pick < 94) ? $urandom_range(111, 127) : $urandom_range(0, 5);
      // Narrow columns keep most soundings short
      pick = $urandom_range(99);
      bi = (pick < 60) ? 3 : (pick < 80) ? 2 : (pick < 92) ? 1 : 0;
      pick = $urandom_range(99);
      ts = (pick < 75) ? $urandom_range(128, srsm_pkg::MAX_TRANSFORM) :
           (pick < 82) ? srsm_pkg::MAX_TRANSFORM :
           (pick < 88) ? $urandom_range(1, 127) :
           (pick < 94) ? $urandom_range(srsm_pkg::MAX_TRANSFORM + 1, 4095) : 0;
      write_reg(srsm_pkg::REG_UPLINK_RB, nrb);
      write_reg(srsm_pkg::REG_BW_CONFIG, $urandom_range(7));
      write_reg(srsm_pkg::REG_BW_INDEX, bi);
      write_reg(srsm_pkg::REG_SF_CONFIG, $urandom_range(15));
      write_reg(srsm_pkg::REG_FREQ_POS, $urandom_range(255));
      write_reg(srsm_pkg::REG_COMB, $urandom_range(1));
      write_reg(srsm_pkg::REG_FIRST_CARRIER, $urandom_range(2047));
      write_reg(srsm_pkg::REG_TRANSFORM_SIZE, ts);
      setups++;

      repeat ($urandom_range(1, 3)) begin
        msc = srsm_pkg::MSC_PER_RB * bw_entry(reg_shadow, reg_shadow.bandwidth_index);
        // Mostly pick a subframe that sounds
        sf = $urandom_range(9);
        if ($urandom_range(9) < 7) begin
          tries = 0;
          while (!subframe_sounds(reg_shadow, sf) && tries < 20) begin
            sf = $urandom_range(9);
            tries++;
          end
        end else if ($urandom_range(3) == 0) begin
          sf = $urandom_range(10, 15);
        end
        // Cut long soundings short most of the time, and a few short ones too
        len = msc;
        if ((msc > 150 && $urandom_range(3) != 0) || $urandom_range(9) == 0)
          len = $urandom_range(1, (msc < 40) ? msc : 40);
        queue_sample(1, sf, $urandom, $urandom, $urandom);
        repeat (len - 1) queue_sample(0, $urandom_range(15), $urandom, $urandom, $urandom);
        // Trailing samples past the end, and now and then some noise
        repeat ($urandom_range(2)) queue_sample(0, $urandom_range(15), $urandom, $urandom,
                                                $urandom);
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 4))
            queue_sample($urandom_range(3) == 0, $urandom_range(15), $urandom, $urandom,
                         $urandom);
      end
    end

    quiesce(END_CYCLES);
    $display("Covered %0d samples over %0d random setups: %0d placed, %0d off-subframe,",
             samples_accepted, setups, status_seen[srsm_pkg::ST_PLACED],
             status_seen[srsm_pkg::ST_SKIPPED]);
    $display("  %0d invalid, %0d past the sequence, %0d sequence ends; %0d mismatches",
             status_seen[srsm_pkg::ST_INVALID], status_seen[srsm_pkg::ST_IDLE], lasts_seen,
             mismatches);
    if (mismatches == 0 && expected_elements.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/srsm_pkg.sv
hdl/srsm_if.sv
hdl/srsm_cfg_regs.sv
hdl/srsm_div.sv
hdl/srsm_mul.sv
hdl/sounding_ref_subcarrier_mapper.sv
tb/tb.sv
